FILE: hdl/tsvrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsvrc_pkg;

    localparam int unsigned COLUMN_LIMIT_DEF = 32'd65535;
    localparam int unsigned COL_W = 16;
    localparam int unsigned CODE_W = 21;

    typedef enum logic [2:0] {
        SC_START  = 3'd0,
        SC_BARE   = 3'd1,
        SC_QUOTED = 3'd2,
        SC_CLOSED = 3'd3,
        SC_PENDQ  = 3'd4
    } scan_state_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_BLANK     = 4'd1,
        ST_UTF8      = 4'd2,
        ST_BOM       = 4'd3,
        ST_COMMENT   = 4'd4,
        ST_CTRL      = 4'd5,
        ST_TAB_QUOTE = 4'd6,
        ST_AFTER_Q   = 4'd7,
        ST_STRAY_Q   = 4'd8,
        ST_UNCLOSED  = 4'd9
    } status_t;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_EOR  = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] BOM_B0   = 8'hEF;
    localparam logic [7:0] BOM_B1   = 8'hBB;
    localparam logic [7:0] BOM_B2   = 8'hBF;

    localparam logic [CODE_W-1:0] CP_MIN3   = 21'h000800;
    localparam logic [CODE_W-1:0] CP_MIN4   = 21'h010000;
    localparam logic [CODE_W-1:0] CP_MAX    = 21'h10FFFF;
    localparam logic [CODE_W-1:0] CP_SUR_LO = 21'h00D800;
    localparam logic [CODE_W-1:0] CP_SUR_HI = 21'h00DFFF;

endpackage

`default_nettype wire

FILE: hdl/tsv_record_checker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// an end-of-record item passes from the input register to the result register, which drives m_tdata
// throughput: one item per cycle while no end-of-record item waits, with one state update per byte
// data items keep flowing while a result waits; only an end-of-record item
// stalls, in the input register, until the result register is free
// reset: synchronous active-low aresetn clears control and record state

module tsv_record_checker_core #(
    parameter int unsigned COLUMN_LIMIT = tsvrc_pkg::COLUMN_LIMIT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // status [3:0], column [19:4], zero pad
);
    import tsvrc_pkg::*;

    localparam logic [COL_W-1:0] ColCap =
        (COLUMN_LIMIT < 32'd65535) ? COLUMN_LIMIT[COL_W-1:0] : 16'hFFFF;
    localparam logic [COL_W-1:0] ColOne = 16'd1;

    // input register
    logic            in_valid_reg, in_valid_next;
    logic            in_func_reg;
    logic [7:0]      in_byte_reg;

    // result register
    logic            out_valid_reg, out_valid_next;
    logic [3:0]      out_status_reg, out_status_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;

    // record state
    scan_state_t      scan_reg, scan_next;
    logic [COL_W-1:0] colcnt_reg, colcnt_next;
    logic [3:0]       serr_reg, serr_next;
    logic [COL_W-1:0] ecol_reg, ecol_next;
    logic [1:0]       urem_reg, urem_next;
    logic [1:0]       ulen_reg, ulen_next;
    logic [CODE_W-1:0] ucode_reg, ucode_next;
    logic             ubad_reg, ubad_next;
    logic [1:0]       bomp_reg, bomp_next;
    logic             bom_reg, bom_next;
    logic             cmt_reg, cmt_next;
    logic             any_reg, any_next;

    logic             out_free;
    logic             consume;
    logic             s_acc;
    logic [7:0]       b;
    logic [CODE_W-1:0] code_sh;
    logic             scan_go;
    logic             is_ctrl;

    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && (in_func_reg == FUNC_DATA || out_free);
    assign s_tready = !in_valid_reg || consume;
    assign s_acc    = s_tvalid && s_tready;
    assign b        = in_byte_reg;
    assign code_sh  = {ucode_reg[CODE_W-7:0], b[5:0]};
    assign is_ctrl  = (b == CH_NUL) || (b == CH_CR) || (b == CH_LF);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_col_reg, out_status_reg};

    always_comb begin
        in_valid_next   = s_acc ? 1'b1 : (consume ? 1'b0 : in_valid_reg);
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_col_next    = out_col_reg;

        scan_next   = scan_reg;
        colcnt_next = colcnt_reg;
        serr_next   = serr_reg;
        ecol_next   = ecol_reg;
        urem_next   = urem_reg;
        ulen_next   = ulen_reg;
        ucode_next  = ucode_reg;
        ubad_next   = ubad_reg;
        bomp_next   = bomp_reg;
        bom_next    = bom_reg;
        cmt_next    = cmt_reg;
        any_next    = any_reg;
        scan_go     = 1'b1;

        if (consume && in_func_reg == FUNC_DATA) begin
            if (!any_reg && b == CH_HASH) begin
                cmt_next = 1'b1;
            end
            any_next = 1'b1;

            // utf-8 validator
            if (urem_reg == 2'd0) begin
                if (b >= 8'hC2 && b <= 8'hDF) begin
                    ulen_next  = 2'd1;
                    urem_next  = 2'd1;
                    ucode_next = {16'd0, b[4:0]};
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    ulen_next  = 2'd2;
                    urem_next  = 2'd2;
                    ucode_next = {17'd0, b[3:0]};
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    ulen_next  = 2'd3;
                    urem_next  = 2'd3;
                    ucode_next = {18'd0, b[2:0]};
                end else if (b[7]) begin
                    ubad_next = 1'b1;
                    ulen_next = 2'd0;
                end
            end else if (b[7:6] != 2'b10) begin
                ubad_next  = 1'b1;
                urem_next  = 2'd0;
                ulen_next  = 2'd0;
                ucode_next = '0;
            end else begin
                urem_next  = urem_reg - 2'd1;
                ucode_next = code_sh;
                if (urem_reg == 2'd1) begin
                    if ((ulen_reg == 2'd2 && code_sh < CP_MIN3) ||
                        (ulen_reg == 2'd3 && code_sh < CP_MIN4) ||
                        code_sh > CP_MAX ||
                        (code_sh >= CP_SUR_LO && code_sh <= CP_SUR_HI)) begin
                        ubad_next = 1'b1;
                    end
                    ulen_next  = 2'd0;
                    ucode_next = '0;
                end
            end

            // byte-order mark watcher
            if (bomp_reg == 2'd2 && b == BOM_B2) begin
                bom_next = 1'b1;
            end
            if (b == BOM_B0) begin
                bomp_next = 2'd1;
            end else if (bomp_reg == 2'd1 && b == BOM_B1) begin
                bomp_next = 2'd2;
            end else begin
                bomp_next = 2'd0;
            end

            // quoting machine, frozen after the first structural error
            if (serr_reg == 4'd0) begin
                if (scan_reg == SC_PENDQ) begin
                    if (b == CH_QUOTE) begin
                        scan_next = SC_QUOTED;
                        scan_go   = 1'b0;
                    end else begin
                        scan_next = SC_CLOSED;
                    end
                end
                if (scan_go) begin
                    if (is_ctrl) begin
                        serr_next = ST_CTRL;
                        ecol_next = colcnt_reg;
                    end else if (scan_reg == SC_QUOTED) begin
                        if (b == CH_TAB) begin
                            serr_next = ST_TAB_QUOTE;
                            ecol_next = colcnt_reg;
                        end else if (b == CH_QUOTE) begin
                            scan_next = SC_PENDQ;
                        end
                    end else if (b == CH_TAB) begin
                        if (colcnt_reg < ColCap) begin
                            colcnt_next = colcnt_reg + ColOne;
                        end
                        scan_next = SC_START;
                    end else if (scan_reg == SC_CLOSED || scan_reg == SC_PENDQ) begin
                        serr_next = ST_AFTER_Q;
                        ecol_next = colcnt_reg;
                    end else if (b == CH_QUOTE) begin
                        if (scan_reg != SC_START) begin
                            serr_next = ST_STRAY_Q;
                            ecol_next = colcnt_reg;
                        end else begin
                            scan_next = SC_QUOTED;
                        end
                    end else begin
                        scan_next = SC_BARE;
                    end
                end
            end
        end else if (consume) begin
            out_valid_next = 1'b1;
            out_col_next   = ColOne;
            if (!any_reg) begin
                out_status_next = ST_BLANK;
            end else if (ubad_reg || urem_reg != 2'd0) begin
                out_status_next = ST_UTF8;
            end else if (bom_reg) begin
                out_status_next = ST_BOM;
            end else if (cmt_reg) begin
                out_status_next = ST_COMMENT;
            end else if (serr_reg != 4'd0) begin
                out_status_next = serr_reg;
                out_col_next    = ecol_reg;
            end else if (scan_reg == SC_QUOTED) begin
                out_status_next = ST_UNCLOSED;
                out_col_next    = colcnt_reg;
            end else begin
                out_status_next = ST_OK;
                out_col_next    = colcnt_reg;
            end
            scan_next   = SC_START;
            colcnt_next = ColOne;
            serr_next   = 4'd0;
            ecol_next   = ColOne;
            urem_next   = 2'd0;
            ulen_next   = 2'd0;
            ucode_next  = '0;
            ubad_next   = 1'b0;
            bomp_next   = 2'd0;
            bom_next    = 1'b0;
            cmt_next    = 1'b0;
            any_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_reg      <= SC_START;
            colcnt_reg    <= ColOne;
            serr_reg      <= 4'd0;
            ecol_reg      <= ColOne;
            urem_reg      <= 2'd0;
            ulen_reg      <= 2'd0;
            ucode_reg     <= '0;
            ubad_reg      <= 1'b0;
            bomp_reg      <= 2'd0;
            bom_reg       <= 1'b0;
            cmt_reg       <= 1'b0;
            any_reg       <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            scan_reg      <= scan_next;
            colcnt_reg    <= colcnt_next;
            serr_reg      <= serr_next;
            ecol_reg      <= ecol_next;
            urem_reg      <= urem_next;
            ulen_reg      <= ulen_next;
            ucode_reg     <= ucode_next;
            ubad_reg      <= ubad_next;
            bomp_reg      <= bomp_next;
            bom_reg       <= bom_next;
            cmt_reg       <= cmt_next;
            any_reg       <= any_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_func_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        out_status_reg <= out_status_next;
        out_col_reg    <= out_col_next;
    end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tsvrc_pkg::*;

    localparam int unsigned COL_CAP =
        (COLUMN_LIMIT_DEF < 32'd65535) ? COLUMN_LIMIT_DEF : 32'd65535;

    typedef struct packed {
        status_t     status;
        logic [15:0] column;
    } verdict_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // data_byte
    logic        s_tuser  = 1'b0;    // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // status [3:0], column [19:4], zero pad

    tsv_record_checker_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // record checker state as predicted
    scan_state_t pr_scan;
    logic [15:0] pr_cols;
    status_t     pr_err;
    logic [15:0] pr_err_col;
    logic [1:0]  pr_u8_rem;
    logic [1:0]  pr_u8_len;
    logic [20:0] pr_u8_code;
    logic        pr_u8_bad;
    logic [1:0]  pr_bom_prog;
    logic        pr_bom_seen;
    logic        pr_hash;
    logic        pr_any;

    verdict_t    pending_verdicts[$];
    logic [7:0]  rec_bytes[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned items_sent    = 0;
    int unsigned bytes_sent    = 0;
    int unsigned records_sent  = 0;
    int unsigned results_seen  = 0;
    int unsigned fault_count   = 0;
    int unsigned status_hits[0:9];

    function automatic void clear_predictor();
        pr_scan     = SC_START;
        pr_cols     = 16'd1;
        pr_err      = ST_OK;
        pr_err_col  = 16'd1;
        pr_u8_rem   = 2'd0;
        pr_u8_len   = 2'd0;
        pr_u8_code  = '0;
        pr_u8_bad   = 1'b0;
        pr_bom_prog = 2'd0;
        pr_bom_seen = 1'b0;
        pr_hash     = 1'b0;
        pr_any      = 1'b0;
    endfunction

    function automatic void utf8_track(input logic [7:0] b);
        if (pr_u8_rem == 2'd0) begin
            if (b >= 8'h80) begin
                if (b >= 8'hC2 && b <= 8'hDF) begin
                    pr_u8_len  = 2'd1;
                    pr_u8_code = {16'd0, b[4:0]};
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    pr_u8_len  = 2'd2;
                    pr_u8_code = {17'd0, b[3:0]};
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    pr_u8_len  = 2'd3;
                    pr_u8_code = {18'd0, b[2:0]};
                end else begin
                    pr_u8_bad = 1'b1;
                    pr_u8_len = 2'd0;
                end
                pr_u8_rem = pr_u8_len;
            end
        end else if (b[7:6] != 2'b10) begin
            pr_u8_bad  = 1'b1;
            pr_u8_rem  = 2'd0;
            pr_u8_len  = 2'd0;
            pr_u8_code = '0;
        end else begin
            pr_u8_code = {pr_u8_code[14:0], b[5:0]};
            pr_u8_rem  = pr_u8_rem - 2'd1;
            if (pr_u8_rem == 2'd0) begin
                if ((pr_u8_len == 2'd2 && pr_u8_code < CP_MIN3) ||
                    (pr_u8_len == 2'd3 && pr_u8_code < CP_MIN4) ||
                    pr_u8_code > CP_MAX ||
                    (pr_u8_code >= CP_SUR_LO && pr_u8_code <= CP_SUR_HI))
                    pr_u8_bad = 1'b1;
                pr_u8_len  = 2'd0;
                pr_u8_code = '0;
            end
        end
    endfunction

    function automatic void bom_track(input logic [7:0] b);
        if (pr_bom_prog == 2'd2 && b == BOM_B2)
            pr_bom_seen = 1'b1;
        if (b == BOM_B0)
            pr_bom_prog = 2'd1;
        else if (pr_bom_prog == 2'd1 && b == BOM_B1)
            pr_bom_prog = 2'd2;
        else
            pr_bom_prog = 2'd0;
    endfunction

    function automatic void mark_fault(input status_t code);
        pr_err     = code;
        pr_err_col = pr_cols;
    endfunction

    function automatic void scan_track(input logic [7:0] c);
        logic taken;
        taken = 1'b0;
        if (pr_err == ST_OK) begin
            if (pr_scan == SC_PENDQ) begin
                if (c == CH_QUOTE) begin
                    pr_scan = SC_QUOTED;
                    taken   = 1'b1;
                end else begin
                    pr_scan = SC_CLOSED;
                end
            end
            if (!taken) begin
                if (c == CH_NUL || c == CH_CR || c == CH_LF) begin
                    mark_fault(ST_CTRL);
                end else if (pr_scan == SC_QUOTED) begin
                    if (c == CH_TAB)
                        mark_fault(ST_TAB_QUOTE);
                    else if (c == CH_QUOTE)
                        pr_scan = SC_PENDQ;
                end else if (c == CH_TAB) begin
                    if (pr_cols < COL_CAP)
                        pr_cols = pr_cols + 16'd1;
                    pr_scan = SC_START;
                end else if (pr_scan == SC_CLOSED) begin
                    mark_fault(ST_AFTER_Q);
                end else if (c == CH_QUOTE) begin
                    if (pr_scan != SC_START)
                        mark_fault(ST_STRAY_Q);
                    else
                        pr_scan = SC_QUOTED;
                end else begin
                    pr_scan = SC_BARE;
                end
            end
        end
    endfunction

    function automatic void predict_item(input logic fn, input logic [7:0] b);
        verdict_t v;
        if (fn == FUNC_DATA) begin
            if (!pr_any && b == CH_HASH)
                pr_hash = 1'b1;
            pr_any = 1'b1;
            utf8_track(b);
            bom_track(b);
            scan_track(b);
        end else begin
            v.column = 16'd1;
            if (!pr_any) begin
                v.status = ST_BLANK;
            end else if (pr_u8_bad || pr_u8_rem != 2'd0) begin
                v.status = ST_UTF8;
            end else if (pr_bom_seen) begin
                v.status = ST_BOM;
            end else if (pr_hash) begin
                v.status = ST_COMMENT;
            end else if (pr_err != ST_OK) begin
                v.status = pr_err;
                v.column = pr_err_col;
            end else if (pr_scan == SC_QUOTED) begin
                v.status = ST_UNCLOSED;
                v.column = pr_cols;
            end else begin
                v.status = ST_OK;
                v.column = pr_cols;
            end
            pending_verdicts = {pending_verdicts, v};
            clear_predictor();
        end
    endfunction

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endtask

    task automatic add_byte(input logic [7:0] v);
        rec_bytes = {rec_bytes, v};
    endtask

    task automatic send_item(input logic fn, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_item(fn, b);
        items_sent++;
        if (fn == FUNC_DATA)
            bytes_sent++;
    endtask

    task automatic send_record();
        foreach (rec_bytes[i])
            send_item(FUNC_DATA, rec_bytes[i]);
        send_item(FUNC_EOR, 8'($urandom_range(255)));
        rec_bytes.delete();
        records_sent++;
    endtask

    // encodes cp in exactly len bytes, so overlong and out-of-range forms come out too
    task automatic add_utf8(input logic [20:0] cp, input int len);
        case (len)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_text_char(input logic in_quotes);
        int unsigned r;
        logic [7:0]  c;
        logic [20:0] cp;
        r = $urandom_range(99);
        if (r < 60) begin
            c = 8'($urandom_range(8'h20, 8'h7E));
            if (c == CH_QUOTE && in_quotes) begin
                add_byte(CH_QUOTE);
                add_byte(CH_QUOTE);
            end else if (c == CH_QUOTE) begin
                add_byte(8'h78);
            end else begin
                add_byte(c);
            end
        end else if (r < 72) begin
            add_utf8(21'($urandom_range(12'h080, 12'h7FF)), 2);
        end else if (r < 86) begin
            cp = 21'($urandom_range(16'h0800, 16'hFFFF));
            if (cp >= CP_SUR_LO && cp <= CP_SUR_HI)
                cp = cp ^ 21'h002000;
            add_utf8(cp, 3);
        end else if (r < 96) begin
            add_utf8(21'($urandom_range(21'h010000, 21'h10FFFF)), 4);
        end else begin
            case ($urandom_range(7))
                0: add_utf8(21'h000080, 2);
                1: add_utf8(21'h0007FF, 2);
                2: add_utf8(21'h000800, 3);
                3: add_utf8(21'h00D7FF, 3);
                4: add_utf8(21'h00E000, 3);
                5: add_utf8(21'h00FFFF, 3);
                6: add_utf8(21'h010000, 4);
                default: add_utf8(CP_MAX, 4);
            endcase
        end
    endtask

    task automatic add_bad_utf8();
        case ($urandom_range(6))
            0: add_utf8(21'($urandom_range(8'h7F)), 2);
            1: add_utf8(21'($urandom_range(12'h7FF)), 3);
            2: add_utf8(21'($urandom_range(16'hFFFF)), 4);
            3: add_utf8(21'($urandom_range(CP_SUR_LO, CP_SUR_HI)), 3);
            4: add_utf8(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
            5: add_byte(8'($urandom_range(8'hC2, 8'hF4)));
            default: add_byte(8'($urandom_range(8'hF5, 8'hFF)));
        endcase
    endtask

    task automatic add_fault();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(2))
                    0: add_byte(CH_NUL);
                    1: add_byte(CH_CR);
                    default: add_byte(CH_LF);
                endcase
            end
            1: add_byte(CH_QUOTE);
            2: add_byte(CH_TAB);
            3: add_bad_utf8();
            4: begin
                add_byte(BOM_B0);
                add_byte(BOM_B1);
                add_byte(BOM_B2);
            end
            5: add_byte(8'($urandom_range(255)));
            6: add_byte(8'($urandom_range(8'h80, 8'hBF)));
            default: begin
                add_byte(CH_QUOTE);
                add_byte(8'h79);
            end
        endcase
    endtask

    task automatic add_cell_text(input logic in_quotes, input logic faulty);
        int n;
        n = $urandom_range(in_quotes ? 0 : 1, 6);
        repeat (n) begin
            if (faulty && $urandom_range(99) < 8)
                add_fault();
            else
                add_text_char(in_quotes);
        end
    endtask

    task automatic build_random_record();
        int unsigned r;
        int unsigned kind;
        int          ncells;
        logic        faulty;
        r = $urandom_range(99);
        if (r < 3) begin
            // blank record
        end else if (r < 13) begin
            repeat ($urandom_range(1, 12))
                add_byte(8'($urandom_range(255)));
        end else begin
            ncells = $urandom_range(1, 5);
            faulty = ($urandom_range(99) < 35);
            if ($urandom_range(99) < 4)
                add_byte(CH_HASH);
            for (int ci = 0; ci < ncells; ci++) begin
                if (ci > 0)
                    add_byte(CH_TAB);
                kind = $urandom_range(9);
                if (kind >= 7) begin
                    add_byte(CH_QUOTE);
                    add_cell_text(1'b1, faulty);
                    if (!(ci == ncells - 1 && faulty && $urandom_range(99) < 25))
                        add_byte(CH_QUOTE);
                end else if (kind >= 2) begin
                    add_cell_text(1'b0, faulty);
                end
            end
        end
    endtask

    task automatic test_blank_and_ok();
        send_record();
        rec_bytes = '{CH_QUOTE, CH_QUOTE, CH_QUOTE, CH_QUOTE, CH_TAB,
                      8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_record();
        rec_bytes = '{8'h7F, CH_TAB, CH_TAB};
        send_record();
    endtask

    task automatic test_utf8_edges();
        rec_bytes = '{8'hE2, 8'h82};
        send_record();
        rec_bytes = '{8'hED, 8'hA0, 8'h80};
        send_record();
        rec_bytes = '{8'hC0, 8'h80};
        send_record();
        rec_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_record();
    endtask

    task automatic test_flag_priority();
        rec_bytes = '{8'h61, BOM_B0, BOM_B1, BOM_B2};
        send_record();
        rec_bytes = '{CH_HASH, 8'h61};
        send_record();
        rec_bytes = '{CH_HASH, 8'hFF};
        send_record();
        rec_bytes = '{BOM_B0, BOM_B1, BOM_B2, CH_QUOTE};
        send_record();
    endtask

    task automatic test_quoting_errors();
        rec_bytes = '{8'h61, CH_TAB, CH_NUL};
        send_record();
        rec_bytes = '{CH_QUOTE, CH_TAB};
        send_record();
        rec_bytes = '{CH_QUOTE, 8'h61, CH_QUOTE, 8'h62};
        send_record();
        rec_bytes = '{8'h61, CH_QUOTE, CH_CR};
        send_record();
        rec_bytes = '{CH_QUOTE, 8'h61};
        send_record();
        rec_bytes = '{8'h61, CH_TAB, CH_QUOTE, 8'h61, CH_QUOTE};
        send_record();
    endtask

    // a wide record of empty cells, once clean and once ending in a stray quote
    task automatic test_many_columns();
        for (int pass = 0; pass < 2; pass++) begin
            repeat (100)
                add_byte(CH_TAB);
            if (pass == 1) begin
                add_byte(8'h61);
                add_byte(CH_QUOTE);
            end
            send_record();
        end
    endtask

    task automatic test_random_records(input int unsigned n_items);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < n_items) begin
            build_random_record();
            send_record();
        end
    endtask

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin : result_check
        verdict_t    want;
        logic [3:0]  got_status;
        logic [15:0] got_column;
        if (aresetn && m_tvalid && m_tready) begin
            got_status = m_tdata[3:0];
            got_column = m_tdata[19:4];
            results_seen++;
            if (got_status <= 4'd9)
                status_hits[got_status]++;
            if (pending_verdicts.size() == 0) begin
                report_fault($sformatf("unexpected result: status %0d column %0d",
                                       got_status, got_column));
            end else begin
                want = pending_verdicts.pop_front();
                if (got_status != want.status || got_column != want.column)
                    report_fault($sformatf(
                        {"mismatch at result %0d: expected status %0d column %0d, ",
                         "got status %0d column %0d"},
                        results_seen, want.status, want.column, got_status, got_column));
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int unsigned drain;
        int unsigned kinds;
        foreach (status_hits[i])
            status_hits[i] = 0;
        clear_predictor();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 35;
        recv_idle_pct = 53;
        test_blank_and_ok();
        test_utf8_edges();
        test_flag_priority();
        test_quoting_errors();
        test_random_records(540);

        send_idle_pct = 53;
        recv_idle_pct = 35;
        test_random_records(540);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_many_columns();
        test_random_records(540);
        s_tvalid <= 1'b0;

        drain = 0;
        while (pending_verdicts.size() != 0 && drain < 10000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (8) @(posedge aclk);
        if (pending_verdicts.size() != 0)
            report_fault($sformatf("%0d results never arrived", pending_verdicts.size()));

        kinds = 0;
        foreach (status_hits[i])
            if (status_hits[i] != 0)
                kinds++;
        $display("Checked %0d record results from %0d records (%0d data bytes, %0d items)",
                 results_seen, records_sent, bytes_sent, items_sent);
        $display("Status codes seen: %0d of 10, faults found: %0d", kinds, fault_count);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: tsv_record_checker_core.f
hdl/tsvrc_pkg.sv
hdl/tsv_record_checker_core.sv
tb/tb_top.sv
